/* sv/bes_pkg.sv */
// ----------------------------------------------------------------------------
// bes_pkg
// Shared types and constants for the breakpoint envelope with sustain loop.
// ----------------------------------------------------------------------------
package bes_pkg;

   // point store
   localparam int MAX_POINTS = 16;
   localparam int PT_AW      = $clog2(MAX_POINTS);
   localparam int CSR_W      = 5;

   // interpolation numerator and serial divider
   localparam int NUM_W         = 35;
   localparam int DIV_STEP_BITS = 3;
   localparam int DIV_W         = ((NUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
   localparam int DIV_STEPS     = DIV_W / DIV_STEP_BITS;
   localparam int DIV_CW        = $clog2(DIV_STEPS);

   // register indexes of the configuration port
   localparam logic [1:0] CSR_POINT_COUNT   = 2'd0;
   localparam logic [1:0] CSR_SUSTAIN_START = 2'd1;
   localparam logic [1:0] CSR_SUSTAIN_END   = 2'd2;
   localparam logic [1:0] CSR_RELEASE_JUMP  = 2'd3;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_KEY_OFF = 2'd1,
      OP_RESTART = 2'd2,
      OP_WRITE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPLY,
      ST_RD0,
      ST_RD1,
      ST_LAT,
      ST_MUL0,
      ST_MUL1,
      ST_SUM,
      ST_DIVS,
      ST_DIVW,
      ST_FIN,
      ST_ADV,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic apply;
      logic rd_first;
      logic lat_first;
      logic rd_second;
      logic lat_second;
      logic mul_first;
      logic mul_second;
      logic sum;
      logic div_start;
      logic finish;
      logic advance;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   at_last;
      logic   flat;
      logic   div_busy;
   } ctrl_status_type;

endpackage

/* sv/bes_div.sv */
// ----------------------------------------------------------------------------
// bes_div
// Serial restoring divider, a few quotient bits per cycle, with Q1.15
// saturation of the truncated signed quotient.
// ----------------------------------------------------------------------------
module bes_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [bes_pkg::NUM_W-1:0]  dividend,
   input  logic        [15:0]                divisor,
   output logic                              busy,
   output logic signed [15:0]                quotient
);
   import bes_pkg::*;

   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [15:0]       rem_ff, rem_in;
   logic [15:0]       dsr_ff;
   logic              neg_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              busy_ff;
   logic [NUM_W-1:0]  mag;
   logic              over;

   assign mag = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);

   // several restoring steps per cycle
   always_comb begin
      logic [16:0] trial;
      logic [15:0] r;
      logic [DIV_W-1:0] d;
      r = rem_ff;
      d = dvd_ff;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
         trial = {r, d[DIV_W-1]};
         d     = {d[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            r    = 16'(trial - {1'b0, dsr_ff});
            d[0] = 1'b1;
         end else begin
            r = trial[15:0];
         end
      end
      rem_in = r;
      dvd_in = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {{(DIV_W - NUM_W){1'b0}}, mag};
         rem_ff <= '0;
         dsr_ff <= divisor;
         neg_ff <= dividend[NUM_W-1];
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   // clamp the magnitude to the Q1.15 range of its sign
   always_comb begin
      if (neg_ff) begin
         over     = (|dvd_ff[DIV_W-1:16]) || (dvd_ff[15] && (|dvd_ff[14:0]));
         quotient = over ? 16'sh8000 : -$signed(dvd_ff[15:0]);
      end else begin
         over     = |dvd_ff[DIV_W-1:15];
         quotient = over ? 16'sh7fff : $signed(dvd_ff[15:0]);
      end
   end

   assign busy = busy_ff;

endmodule

/* sv/bes_dpath.sv */
// ----------------------------------------------------------------------------
// bes_dpath
// Envelope datapath: point memory, configuration, segment state, shared
// multiplier, serial divider and the result register.
// ----------------------------------------------------------------------------
module bes_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  bes_pkg::ctrl_cmd_type     cmd,
   output bes_pkg::ctrl_status_type  status,
   input  logic [1:0]                req_op,
   input  logic [3:0]                req_point_index,
   input  logic [15:0]               req_point_time,
   input  logic signed [15:0]        req_point_value,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [bes_pkg::CSR_W-1:0] csr_write_data,
   output logic signed [15:0]        rsp_level,
   output logic [3:0]                rsp_segment,
   output logic                      rsp_finished,
   output logic                      rsp_is_released
);
   import bes_pkg::*;

   // configuration
   logic [4:0]        pc_ff;
   logic signed [4:0] ss_ff, se_ff;
   logic              rj_ff;

   // captured word
   op_type            op_ff;
   logic [PT_AW-1:0]  idx_ff;
   logic [15:0]       time_ff;
   logic [15:0]       value_ff;

   // envelope state
   logic [PT_AW-1:0]  seg_ff, seg_in;
   logic [15:0]       pos_ff, pos_in;
   logic              rel_ff, rel_in;
   logic              done_ff, done_in;

   // point memory, {time, value}
   logic [31:0]       pt_mem [MAX_POINTS];
   logic [31:0]       rd_ff;
   logic [PT_AW-1:0]  rd_addr;

   logic [15:0]        t0_ff, t1_ff;
   logic signed [15:0] v0_ff, v1_ff;
   logic signed [16:0] seg_len;
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] mul_p;
   logic signed [33:0] prod_ff, acc_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic signed [15:0] level_ff;
   logic signed [15:0] div_quot;
   logic               div_busy;

   logic [4:0]         pc_clamp;
   logic [PT_AW-1:0]   last;
   logic               at_last;

   logic signed [15:0] rsp_level_ff;
   logic [PT_AW-1:0]   rsp_segment_ff;
   logic               rsp_finished_ff, rsp_released_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 5'd2;
         ss_ff <= -5'sd1;
         se_ff <= -5'sd1;
         rj_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POINT_COUNT:   pc_ff <= csr_write_data;
            CSR_SUSTAIN_START: ss_ff <= $signed(csr_write_data);
            CSR_SUSTAIN_END:   se_ff <= $signed(csr_write_data);
            CSR_RELEASE_JUMP:  rj_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pc_ff < 5'd2) begin
         pc_clamp = 5'd2;
      end else if (pc_ff > 5'(MAX_POINTS)) begin
         pc_clamp = 5'(MAX_POINTS);
      end else begin
         pc_clamp = pc_ff;
      end
   end

   assign last    = PT_AW'(pc_clamp - 5'd1);
   assign at_last = seg_ff >= last;

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         idx_ff   <= req_point_index;
         time_ff  <= req_point_time;
         value_ff <= req_point_value;
      end
   end

   // point memory, one port, registered read
   assign rd_addr = cmd.rd_second ? seg_ff + 1'b1 : (at_last ? last : seg_ff);

   always_ff @(posedge clock) begin
      if (cmd.apply && op_ff == OP_WRITE) begin
         pt_mem[idx_ff] <= {time_ff, value_ff};
      end
      if (cmd.rd_first || cmd.rd_second) begin
         rd_ff <= pt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lat_first) begin
         t0_ff <= rd_ff[31:16];
         v0_ff <= $signed(rd_ff[15:0]);
      end
      if (cmd.lat_second) begin
         t1_ff <= rd_ff[31:16];
         v1_ff <= $signed(rd_ff[15:0]);
      end
   end

   assign seg_len = $signed({1'b0, t1_ff}) - $signed({1'b0, t0_ff});

   // shared multiplier: v0*len first, then (v1-v0)*pos
   always_comb begin
      if (cmd.mul_second) begin
         mul_a = $signed({v1_ff[15], v1_ff}) - $signed({v0_ff[15], v0_ff});
         mul_b = $signed({1'b0, pos_ff});
      end else begin
         mul_a = $signed({v0_ff[15], v0_ff});
         mul_b = seg_len;
      end
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_first || cmd.mul_second) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul_second) begin
         acc_ff <= prod_ff;
      end
      if (cmd.sum) begin
         num_ff <= $signed({acc_ff[33], acc_ff}) + $signed({prod_ff[33], prod_ff});
      end
   end

   bes_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  (seg_len[15:0]),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         level_ff <= (at_last || status.flat) ? v0_ff : div_quot;
      end
   end

   // segment state update
   always_comb begin
      logic               hold;
      logic               wrap;
      logic               loop_back;
      logic [16:0]        pos_nx;
      logic [PT_AW-1:0]   seg_nx;
      seg_in    = seg_ff;
      pos_in    = pos_ff;
      rel_in    = rel_ff;
      done_in   = done_ff;
      hold      = (ss_ff == $signed({1'b0, seg_ff})) && (ss_ff == se_ff) &&
                  (se_ff != -5'sd1) && !rel_ff;
      pos_nx    = {1'b0, pos_ff} + (hold ? 17'd0 : 17'd1);
      wrap      = ({2'b00, t0_ff} + {1'b0, pos_nx}) > {2'b00, t1_ff};
      loop_back = (6'({se_ff[4], se_ff}) - 6'd1 == {2'b00, seg_ff}) && !rel_ff && !ss_ff[4];
      seg_nx    = loop_back ? ss_ff[3:0] : seg_ff + 1'b1;
      if (cmd.apply) begin
         case (op_ff)
            OP_KEY_OFF: begin
               rel_in = 1'b1;
               if (ss_ff[4]) begin
                  done_in = 1'b1;
               end else if (rj_ff && !se_ff[4]) begin
                  pos_in = '0;
                  if (se_ff[3:0] >= last) begin
                     seg_in  = last;
                     done_in = 1'b1;
                  end else begin
                     seg_in = se_ff[3:0];
                  end
               end
            end
            OP_RESTART: begin
               seg_in  = '0;
               pos_in  = '0;
               rel_in  = 1'b0;
               done_in = 1'b0;
            end
            default: ;
         endcase
      end else if (cmd.advance && !done_ff) begin
         if (at_last) begin
            seg_in  = last;
            done_in = 1'b1;
         end else if (wrap) begin
            pos_in = '0;
            if (seg_nx >= last) begin
               seg_in  = last;
               done_in = 1'b1;
            end else begin
               seg_in = seg_nx;
            end
         end else begin
            pos_in = pos_nx[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff  <= '0;
         pos_ff  <= '0;
         rel_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         seg_ff  <= seg_in;
         pos_ff  <= pos_in;
         rel_ff  <= rel_in;
         done_ff <= done_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_level_ff    <= level_ff;
         rsp_segment_ff  <= seg_ff;
         rsp_finished_ff <= done_ff;
         rsp_released_ff <= rel_ff;
      end
   end

   assign rsp_level       = rsp_level_ff;
   assign rsp_segment     = rsp_segment_ff;
   assign rsp_finished    = rsp_finished_ff;
   assign rsp_is_released = rsp_released_ff;

   assign status.op       = op_ff;
   assign status.at_last  = at_last;
   assign status.flat     = seg_len[16] || (seg_len == 17'sd0);
   assign status.div_busy = div_busy;

endmodule

/* sv/bes_ctrl.sv */
// ----------------------------------------------------------------------------
// bes_ctrl
// Sequencer for one word at a time: apply, read points, interpolate,
// advance on a tick, then hand the result to the output register.
// ----------------------------------------------------------------------------
module bes_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  bes_pkg::ctrl_status_type  status,
   output bes_pkg::ctrl_cmd_type     cmd
);
   import bes_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_RD0;
         end
         ST_RD0: begin
            cmd.rd_first = 1'b1;
            state_in     = ST_RD1;
         end
         ST_RD1: begin
            cmd.lat_first = 1'b1;
            if (status.at_last) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_second = 1'b1;
               state_in      = ST_LAT;
            end
         end
         ST_LAT: begin
            cmd.lat_second = 1'b1;
            state_in       = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul_first = 1'b1;
            if (status.flat) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_second = 1'b1;
            state_in       = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (!status.div_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = (status.op == OP_TICK) ? ST_ADV : ST_OUT;
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/breakpoint_envelope_sustain_loop.sv */
// ----------------------------------------------------------------------------
// breakpoint_envelope_sustain_loop
// Breakpoint envelope generator with sustain hold and sustain loop.
// ----------------------------------------------------------------------------
// Usage: each word on the req_ channel is a tick, a key-off, a restart or a
// point write; every word gives exactly one word on the rsp_ channel with the
// level, segment, finished and released flags. Both channels use valid and
// stall; a word moves when valid is high and stall is low. The csr_ port
// writes the point count, sustain start and end and the release-jump flag;
// write it only while no word is in flight.
// One word is worked on at a time; a new word is taken only once the last
// is in the output register. A word whose level falls inside a segment
// spends most of its time in the serial divider (three quotient bits a
// cycle) and the single point memory port; a tick also advances. A word
// at the final point or on a zero-length segment skips the divider.
// Reset clears the envelope state and loads the register defaults; the point
// store keeps whatever it held and must be written before use.
// While the receiver stalls, the finished word holds in the output register;
// the next word is still accepted and worked on, and waits for the register.
// ----------------------------------------------------------------------------
module breakpoint_envelope_sustain_loop (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_point_index,
   input  logic [15:0]        req_point_time,
   input  logic signed [15:0] req_point_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_level,
   output logic [3:0]         rsp_segment,
   output logic               rsp_finished,
   output logic               rsp_is_released,
   // configuration port
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_write_data
);
   import bes_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: one word through apply, read, interpolate and, for a tick, advance
   bes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: point memory, arithmetic, envelope state, output register
   bes_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_point_index  (req_point_index),
      .req_point_time   (req_point_time),
      .req_point_value  (req_point_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_level        (rsp_level),
      .rsp_segment      (rsp_segment),
      .rsp_finished     (rsp_finished),
      .rsp_is_released  (rsp_is_released)
   );

   // a word once taken closes the request side until its result is handed on
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a word was in flight");

   // the divider is running the cycle after it is started
   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");

   // handing on a result always presents it
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result handed on but not presented");

   // a result is only handed on when the output register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_valid || !rsp_stall)
      else $error("result overwrote a stalled word");

endmodule

/* dv/envelope_level_checker.sv */
// ----------------------------------------------------------------------------
// envelope_level_checker
// Predicts the level word for every accepted request word and compares it
// field by field with the words that leave the response channel.
// ----------------------------------------------------------------------------
module envelope_level_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_point_index,
   input  logic [15:0]        req_point_time,
   input  logic signed [15:0] req_point_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_level,
   input  logic [3:0]         rsp_segment,
   input  logic               rsp_finished,
   input  logic               rsp_is_released,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_write_data,
   output int                 fail_count,
   output int                 pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import bes_pkg::*;

   typedef struct {
      logic signed [15:0] level;
      bit                 level_known;
      logic [3:0]         segment;
      logic               finished;
      logic               released;
   } level_word_type;

   level_word_type level_q[$];

   // own copy of the point store; entries never written leave the level open
   logic [15:0]        pt_time  [MAX_POINTS] = '{default: '0};
   logic signed [15:0] pt_value [MAX_POINTS] = '{default: '0};
   bit [MAX_POINTS-1:0] pt_written = '0;

   int seg;
   int pos;
   bit released;
   bit done;

   logic [4:0] cfg_count;
   int         cfg_sus_start;
   int         cfg_sus_end;
   bit         cfg_jump;

   int mismatches = 0;
   int pending    = 0;

   assign fail_count    = mismatches;
   assign pending_words = pending;

   function automatic int last_idx();
      int pc;
      pc = cfg_count;
      if (pc < 2) pc = 2;
      if (pc > MAX_POINTS) pc = MAX_POINTS;
      return pc - 1;
   endfunction

   function automatic void clamp_to_last();
      if (seg >= last_idx()) begin
         seg  = last_idx();
         done = 1'b1;
      end
   endfunction

   function automatic logic signed [15:0] interp_level(output bit known);
      int     lst;
      longint len, v0, v1, num, q;
      lst = last_idx();
      if (seg >= lst) begin
         known = pt_written[lst];
         return pt_value[lst];
      end
      known = pt_written[seg] && pt_written[seg+1];
      v0  = pt_value[seg];
      v1  = pt_value[seg+1];
      len = longint'(pt_time[seg+1]) - longint'(pt_time[seg]);
      if (len <= 0) return pt_value[seg];
      num = v0 * len + (v1 - v0) * longint'(pos);
      q   = num / len;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return 16'(q);
   endfunction

   always @(posedge clock) begin
      level_word_type want;
      logic signed [15:0] lvl;
      bit known;
      int s;
      bit hold;
      if (reset) begin
         seg           = 0;
         pos           = 0;
         released      = 1'b0;
         done          = 1'b0;
         cfg_count     = 5'd2;
         cfg_sus_start = -1;
         cfg_sus_end   = -1;
         cfg_jump      = 1'b0;
         level_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_POINT_COUNT:   cfg_count     = csr_write_data;
               CSR_SUSTAIN_START: cfg_sus_start = $signed(csr_write_data);
               CSR_SUSTAIN_END:   cfg_sus_end   = $signed(csr_write_data);
               CSR_RELEASE_JUMP:  cfg_jump      = csr_write_data[0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            case (op_type'(req_op))
               OP_TICK: begin
                  // level is taken before the position moves
                  lvl = interp_level(known);
                  if (!done) begin
                     if (seg >= last_idx()) begin
                        clamp_to_last();
                     end else begin
                        s    = seg;
                        hold = cfg_sus_start == s && cfg_sus_start == cfg_sus_end &&
                               cfg_sus_end != -1 && !released;
                        if (!hold) pos++;
                        if (longint'(pt_time[s]) + longint'(pos) > longint'(pt_time[s+1])) begin
                           if (s == cfg_sus_end - 1 && !released && cfg_sus_start >= 0)
                              seg = cfg_sus_start;
                           else
                              seg = s + 1;
                           pos = 0;
                           clamp_to_last();
                        end
                     end
                  end
               end
               OP_KEY_OFF: begin
                  released = 1'b1;
                  if (cfg_sus_start < 0) begin
                     done = 1'b1;
                  end else if (cfg_jump && cfg_sus_end >= 0) begin
                     seg = cfg_sus_end;
                     pos = 0;
                     clamp_to_last();
                  end
                  lvl = interp_level(known);
               end
               OP_RESTART: begin
                  seg      = 0;
                  pos      = 0;
                  released = 1'b0;
                  done     = 1'b0;
                  lvl      = interp_level(known);
               end
               default: begin
                  pt_time[req_point_index]    = req_point_time;
                  pt_value[req_point_index]   = req_point_value;
                  pt_written[req_point_index] = 1'b1;
                  lvl = interp_level(known);
               end
            endcase
            want.level       = lvl;
            want.level_known = known;
            want.segment     = 4'(seg);
            want.finished    = done;
            want.released    = released;
            level_q.push_back(want);
         end

         if (rsp_valid && !rsp_stall) begin
            if (level_q.size() == 0) begin
               $error("response word with no request waiting for it");
               mismatches++;
            end else begin
               want = level_q.pop_front();
               if (want.level_known && rsp_level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, rsp_level);
                  mismatches++;
               end
               if (rsp_segment !== want.segment) begin
                  $error("segment: expected %0d, got %0d", want.segment, rsp_segment);
                  mismatches++;
               end
               if (rsp_finished !== want.finished) begin
                  $error("finished: expected %0d, got %0d", want.finished, rsp_finished);
                  mismatches++;
               end
               if (rsp_is_released !== want.released) begin
                  $error("is_released: expected %0d, got %0d", want.released,
                         rsp_is_released);
                  mismatches++;
               end
            end
         end
      end
      pending = level_q.size();
   end

endmodule

/* dv/tb_breakpoint_envelope_sustain_loop.sv */
// ----------------------------------------------------------------------------
// tb_breakpoint_envelope_sustain_loop
// Drives the breakpoint envelope with point loads, restarts, key-offs and
// ticks under a range of point counts and sustain settings, with bursty
// request traffic and a stalling receiver; the checker beside the block
// predicts and compares every level word.
// ----------------------------------------------------------------------------
module tb_breakpoint_envelope_sustain_loop;
   timeunit 1ns;
   timeprecision 1ps;
   import bes_pkg::*;

   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_WORDS  = 1050;
   // quiet time after draining, with a good margin over a word inside a segment
   localparam int SETTLE_CYCLES = 40;
   // long receiver hold-offs, counted in the receiver's own cycles
   localparam int HOLD_A_START  = 5000;
   localparam int HOLD_B_START  = 16000;
   localparam int HOLD_LEN      = 400;

   typedef enum {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op           = OP_TICK;
   logic [3:0]         req_point_index  = '0;
   logic [15:0]        req_point_time   = '0;
   logic signed [15:0] req_point_value  = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [15:0] rsp_level;
   logic [3:0]         rsp_segment;
   logic               rsp_finished;
   logic               rsp_is_released;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index        = CSR_POINT_COUNT;
   logic [4:0]         csr_write_data   = '0;

   int fail_count;
   int pending_words;

   int          cycle_count  = 0;
   int          words_sent   = 0;
   int          burst_left   = 0;
   int          rx_cycle     = 0;
   int          rx_mode_left = 0;
   rx_mode_type rx_mode      = RX_FREE;

   breakpoint_envelope_sustain_loop uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_point_time  (req_point_time),
      .req_point_value (req_point_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_segment     (rsp_segment),
      .rsp_finished    (rsp_finished),
      .rsp_is_released (rsp_is_released),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   envelope_level_checker level_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_point_time  (req_point_time),
      .req_point_value (req_point_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_segment     (rsp_segment),
      .rsp_finished    (rsp_finished),
      .rsp_is_released (rsp_is_released),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending_words   (pending_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Guard against a hung block or a lost word.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_breakpoint_envelope_sustain_loop failed");
         $finish;
      end
   end

   // Receiver: switch to a randomly chosen stall pattern whenever the current one
   // runs out, and twice hold off for a long stretch so that the block backs up
   // and stalls its request side while the sender keeps offering words.
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(32, 256);
      end else begin
         rx_mode_left--;
      end
      if ((rx_cycle >= HOLD_A_START && rx_cycle < HOLD_A_START + HOLD_LEN) ||
          (rx_cycle >= HOLD_B_START && rx_cycle < HOLD_B_START + HOLD_LEN)) begin
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            RX_FREE:     rsp_stall <= 1'b0;
            RX_SPARSE:   rsp_stall <= ($urandom_range(0, 99) < 30);
            RX_PERIODIC: rsp_stall <= (rx_cycle % 4 == 0);
            default:     rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   // Offer one word and hold it until the block takes it. Words go out in
   // bursts; between bursts drop valid for a random gap, which may be zero.
   task automatic send_word(input op_type op, input logic [3:0] idx,
                            input logic [15:0] t, input logic [15:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_point_index <= idx;
      req_point_time  <= t;
      req_point_value <= v;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Drop valid, wait for every predicted word to come back, then let the
   // block go quiet before anything touches the registers.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [4:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Level values: lean on the two extremes now and then.
   function automatic logic [15:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7FFF;
      return 16'($urandom);
   endfunction

   // One setting of the registers: load a fresh envelope, restart it and play
   // it with ticks, usually a key-off somewhere and a little noise.
   task automatic run_phase(input logic [4:0] pc, input logic [4:0] ss,
                            input logic [4:0] se, input logic rj);
      int n, ticks, koff_at, i, r;
      logic [15:0] t;
      wait_drained();
      write_csr(CSR_POINT_COUNT, pc);
      write_csr(CSR_SUSTAIN_START, ss);
      write_csr(CSR_SUSTAIN_END, se);
      write_csr(CSR_RELEASE_JUMP, {4'b0000, rj});

      n = (pc < 2) ? 2 : ((pc > MAX_POINTS) ? MAX_POINTS : int'(pc));
      t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
      for (i = 0; i < n; i++) begin
         send_word(OP_WRITE, 4'(i), t, pick_value());
         // mostly short segments so that ticks get through the envelope;
         // 55..69 keeps the time, giving a zero-length segment
         r = $urandom_range(0, 99);
         if (r < 55)
            t = t + 16'($urandom_range(1, 5));
         else if (r >= 70 && r < 85)
            t = t + 16'($urandom_range(6, 40));
         else if (r >= 85 && r < 93)
            t = t - 16'($urandom_range(1, 20));
         else if (r >= 93)
            t = 16'($urandom);
      end

      send_word(OP_RESTART, 4'($urandom), 16'($urandom), 16'($urandom));
      ticks   = $urandom_range(8, 64);
      koff_at = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, ticks);
      for (i = 0; i < ticks; i++) begin
         if (i == koff_at)
            send_word(OP_KEY_OFF, 4'($urandom), 16'($urandom), 16'($urandom));
         r = $urandom_range(0, 99);
         if (r < 6)
            send_word(op_type'($urandom_range(0, 3)), 4'($urandom), 16'($urandom),
                      pick_value());
         else if (r < 9)
            send_word(OP_RESTART, 4'($urandom), 16'($urandom), 16'($urandom));
         else
            send_word(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      int i, r, goal;
      logic [4:0] pc, ss, se;
      logic rj;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed: fill the whole store with extreme times and levels, then
      // walk the first segment to the final point under the reset settings.
      send_word(OP_WRITE, 4'd0, 16'd0, 16'h8000);
      send_word(OP_WRITE, 4'd1, 16'd4, 16'h7FFF);
      send_word(OP_WRITE, 4'd2, 16'd4, 16'h0000);   // zero-length segment
      send_word(OP_WRITE, 4'd3, 16'hFFFF, 16'hFFFF);
      send_word(OP_WRITE, 4'd4, 16'd10, 16'd12345); // time runs backwards
      for (i = 5; i < MAX_POINTS; i++)
         send_word(OP_WRITE, 4'(i), 16'(20 + 3 * i), (i % 2) ? 16'h8000 : 16'h7FFF);
      send_word(OP_RESTART, 4'd0, 16'd0, 16'd0);
      repeat (6) send_word(OP_TICK, 4'd0, 16'd0, 16'd0);  // last one while finished
      send_word(OP_KEY_OFF, 4'd0, 16'd0, 16'd0);
      // key-off with no sustain finishes at once
      send_word(OP_RESTART, 4'd0, 16'd0, 16'd0);
      send_word(OP_KEY_OFF, 4'd0, 16'd0, 16'd0);
      send_word(OP_TICK, 4'd0, 16'd0, 16'd0);

      goal = words_sent + RANDOM_WORDS;

      // Settings worth a visit on their own: no sustain, single-point hold,
      // loop with and without release jump, point counts out of range, a jump
      // past the final point, and negative sustain values other than -1.
      run_phase(5'd2,  5'h1F, 5'h1F, 1'b0);
      run_phase(5'd16, 5'h1F, 5'h1F, 1'b0);
      run_phase(5'd4,  5'd1,  5'd1,  1'b0);
      run_phase(5'd6,  5'd1,  5'd3,  1'b0);
      run_phase(5'd6,  5'd1,  5'd3,  1'b1);
      run_phase(5'd0,  5'd0,  5'd15, 1'b1);
      run_phase(5'd31, 5'd15, 5'd15, 1'b1);
      run_phase(5'd16, 5'h10, 5'h1B, 1'b0);
      run_phase(5'd16, 5'd0,  5'd15, 1'b0);

      while (words_sent < goal) begin
         pc = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(2, 16)) : 5'($urandom);
         r  = $urandom_range(0, 99);
         ss = (r < 20) ? 5'h1F : ((r < 85) ? 5'($urandom_range(0, 15)) : 5'($urandom));
         r  = $urandom_range(0, 99);
         if (r < 35)
            se = ss;
         else if (r < 50)
            se = 5'h1F;
         else if (r < 90)
            se = 5'($urandom_range(0, 15));
         else
            se = 5'($urandom);
         rj = 1'($urandom);
         run_phase(pc, ss, se, rj);
      end

      // Hold until every word is back and the block has gone quiet.
      wait_drained();
      if (fail_count == 0)
         $display("tb_breakpoint_envelope_sustain_loop passed");
      else
         $display("tb_breakpoint_envelope_sustain_loop failed");
      $finish;
   end

endmodule
